// ===== hw/rtl/avt_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and constants for the affine vector transform core
// no dependencies; imported by the core, its checker and the bench

package avt_pkg;

   localparam int COEFF_W    = 16;
   localparam int ROW_W      = 3 * COEFF_W;
   localparam int VEC_W      = 32;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_W;
   // cofactors are a difference of two 16x16 products, scaled coefficients fit as well
   localparam int CF_W       = 2 * COEFF_W + 1;

   localparam logic [CMD_W-1:0] CMD_LOCATION  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DIRECTION = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NORMAL    = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_ZERO = 3'd0,
      REG_ROW_ONE  = 3'd1,
      REG_ROW_TWO  = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } csr_index_type;

   // identity matrix with 1.0 in Q4.12
   localparam logic [ROW_W-1:0] ROW_ZERO_RESET = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_ONE_RESET  = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_TWO_RESET  = 48'h1000_0000_0000;

   typedef logic signed [COEFF_W-1:0] coeff_type;
   typedef logic signed [CF_W-1:0]    cofactor_type;
   typedef logic signed [VEC_W-1:0]   vec_type;

   // a*b - c*d, exact
   function automatic cofactor_type cof_term(input coeff_type a, input coeff_type b,
                                             input coeff_type c, input coeff_type d);
      cofactor_type pa;
      cofactor_type pb;
      pa = CF_W'(a) * CF_W'(b);
      pb = CF_W'(c) * CF_W'(d);
      return pa - pb;
   endfunction

endpackage

// ===== hw/rtl/affine_vector_transform_core.sv =====
`timescale 1ns / 1ps
// affine vector transform core: 3x3 matrix times vector, plus translation or cofactor form
// depends on avt_pkg
// throughput: one transaction per cycle, four register stages (input, multiply, sum, saturate)
// busy is high only while reset is asserted; the receiver cannot stall the pipeline
// synchronous reset restores the identity matrix, zero offsets and clears all valid bits
// cofactors are registered from the matrix registers, ready the cycle after a config write

module affine_vector_transform_core
   import avt_pkg::*;
#(
   parameter int COEFF_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic signed [VEC_W-1:0] req_vec_x,
   input  logic signed [VEC_W-1:0] req_vec_y,
   input  logic signed [VEC_W-1:0] req_vec_z,
   output logic                  rsp_valid,
   output logic signed [VEC_W-1:0] rsp_out_x,
   output logic signed [VEC_W-1:0] rsp_out_y,
   output logic signed [VEC_W-1:0] rsp_out_z,
   output logic                  rsp_overflow,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PROD_W  = CF_W + VEC_W;
   localparam int TRUNC_W = PROD_W - 2 * COEFF_FRAC_BITS;
   localparam int SUM_W   = TRUNC_W + 2;

   // configuration
   logic [ROW_W-1:0]   row_ff [3];
   vec_type            offset_ff [3];
   coeff_type          m [3][3];
   cofactor_type       cf_in [3][3];
   cofactor_type       cf_ff [3][3];

   // pipeline
   logic               s1_vld_ff;
   logic [CMD_W-1:0]   s1_cmd_ff;
   vec_type            s1_vec_ff [3];

   logic signed [TRUNC_W-1:0] s2_trunc_in [3][3];
   logic signed [TRUNC_W-1:0] s2_trunc_ff [3][3];
   vec_type            s2_off_in [3];
   vec_type            s2_off_ff [3];
   logic               s2_vld_ff;

   logic signed [SUM_W-1:0] s3_sum_in [3];
   logic signed [SUM_W-1:0] s3_sum_ff [3];
   logic               s3_vld_ff;

   vec_type            res_in [3];
   logic [2:0]         sat_in;
   logic               rsp_valid_ff;
   vec_type            rsp_out_ff [3];
   logic               rsp_overflow_ff;

   logic               req_accept;

   assign busy       = reset;
   assign req_accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]    <= ROW_ZERO_RESET;
         row_ff[1]    <= ROW_ONE_RESET;
         row_ff[2]    <= ROW_TWO_RESET;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROW_ZERO: row_ff[0]    <= csr_wdata;
            REG_ROW_ONE:  row_ff[1]    <= csr_wdata;
            REG_ROW_TWO:  row_ff[2]    <= csr_wdata;
            REG_OFFSET_X: offset_ff[0] <= csr_wdata[VEC_W-1:0];
            REG_OFFSET_Y: offset_ff[1] <= csr_wdata[VEC_W-1:0];
            REG_OFFSET_Z: offset_ff[2] <= csr_wdata[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            m[r][c] = row_ff[r][COEFF_W*c +: COEFF_W];
         end
      end
   end

   always_comb begin
      cf_in[0][0] = cof_term(m[1][1], m[2][2], m[2][1], m[1][2]);
      cf_in[0][1] = cof_term(m[0][2], m[2][1], m[2][2], m[0][1]);
      cf_in[0][2] = cof_term(m[0][1], m[1][2], m[1][1], m[0][2]);
      cf_in[1][0] = cof_term(m[1][2], m[2][0], m[2][2], m[1][0]);
      cf_in[1][1] = cof_term(m[0][0], m[2][2], m[2][0], m[0][2]);
      cf_in[1][2] = cof_term(m[0][2], m[1][0], m[1][2], m[0][0]);
      cf_in[2][0] = cof_term(m[1][0], m[2][1], m[2][0], m[1][1]);
      cf_in[2][1] = cof_term(m[0][1], m[2][0], m[2][1], m[0][0]);
      cf_in[2][2] = cof_term(m[0][0], m[1][1], m[1][0], m[0][1]);
   end

   always_ff @(posedge clock) begin
      cf_ff <= cf_in;
   end

   // stage 1: capture the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff    <= req_cmd;
      s1_vec_ff[0] <= req_vec_x;
      s1_vec_ff[1] <= req_vec_y;
      s1_vec_ff[2] <= req_vec_z;
   end

   // stage 2: one multiply per matrix entry
   // plain coefficients are pre-scaled so both forms truncate by 2*frac bits
   always_comb begin
      cofactor_type                sel;
      logic signed [PROD_W-1:0]    prod;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (s1_cmd_ff[1]) begin
               sel = cf_ff[r][c];
            end else begin
               sel = CF_W'(m[r][c]) <<< COEFF_FRAC_BITS;
            end
            prod = PROD_W'(sel) * PROD_W'(s1_vec_ff[c]);
            // dropping low bits of a signed value rounds toward minus infinity
            s2_trunc_in[r][c] = prod[PROD_W-1 -: TRUNC_W];
         end
         s2_off_in[r] = (s1_cmd_ff == CMD_LOCATION) ? offset_ff[r] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_trunc_ff <= s2_trunc_in;
      s2_off_ff   <= s2_off_in;
   end

   // stage 3: row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_sum_in[r] = SUM_W'(s2_trunc_ff[r][0]) + SUM_W'(s2_trunc_ff[r][1])
                      + SUM_W'(s2_trunc_ff[r][2]) + SUM_W'(s2_off_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_sum_ff <= s3_sum_in;
   end

   // stage 4: saturate to 32 bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sat_in[r] = (s3_sum_ff[r][SUM_W-1:VEC_W-1] != {(SUM_W-VEC_W+1){1'b0}})
                   && (s3_sum_ff[r][SUM_W-1:VEC_W-1] != {(SUM_W-VEC_W+1){1'b1}});
         if (sat_in[r]) begin
            res_in[r] = {s3_sum_ff[r][SUM_W-1], {(VEC_W-1){~s3_sum_ff[r][SUM_W-1]}}};
         end else begin
            res_in[r] = s3_sum_ff[r][VEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_ff      <= res_in;
      rsp_overflow_ff <= |sat_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_out_ff[0];
   assign rsp_out_y    = rsp_out_ff[1];
   assign rsp_out_z    = rsp_out_ff[2];
   assign rsp_overflow = rsp_overflow_ff;

   // a flagged transaction must carry at least one clamped component
   a_overflow_clamped: assert property (@(posedge clock)
      (rsp_valid && rsp_overflow) |->
         (rsp_out_x == {1'b0, {(VEC_W-1){1'b1}}} || rsp_out_x == {1'b1, {(VEC_W-1){1'b0}}}
       || rsp_out_y == {1'b0, {(VEC_W-1){1'b1}}} || rsp_out_y == {1'b1, {(VEC_W-1){1'b0}}}
       || rsp_out_z == {1'b0, {(VEC_W-1){1'b1}}} || rsp_out_z == {1'b1, {(VEC_W-1){1'b0}}}))
      else $error("overflow flagged without a saturated component");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s1_vld_ff, 3))
      else $error("result without a transaction three stages back");

   a_no_offset: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_cmd_ff != CMD_LOCATION) |=>
         (s2_off_ff[0] == '0 && s2_off_ff[1] == '0 && s2_off_ff[2] == '0))
      else $error("translation applied to a direction or normal");

endmodule

// ===== bench/avt_transform_checker.sv =====
`timescale 1ns / 1ps
// result checker for affine_vector_transform_core: keeps its own copy of the registers,
// predicts each accepted transaction and compares the strobed results in order
// depends on avt_pkg

module avt_transform_checker
   import avt_pkg::*;
#(
   parameter int COEFF_FRAC_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic signed [VEC_W-1:0] req_vec_x,
   input  logic signed [VEC_W-1:0] req_vec_y,
   input  logic signed [VEC_W-1:0] req_vec_z,
   input  logic                    rsp_valid,
   input  logic signed [VEC_W-1:0] rsp_out_x,
   input  logic signed [VEC_W-1:0] rsp_out_y,
   input  logic signed [VEC_W-1:0] rsp_out_z,
   input  logic                    rsp_overflow,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned             mismatch_count,
   output int unsigned             transforms_in_flight
);

   localparam int MAX_REPORTS = 10;
   localparam longint COMP_MAX = 64'sd2147483647;
   localparam longint COMP_MIN = -64'sd2147483648;

   typedef struct packed {
      vec_type x;
      vec_type y;
      vec_type z;
      logic    overflow;
   } transform_result_type;

   logic [ROW_W-1:0]     row_coeffs [3];
   vec_type              offsets [3];
   transform_result_type pending_transforms [$];
   int unsigned          mismatches = 0;
   int unsigned          queued = 0;

   assign mismatch_count       = mismatches;
   assign transforms_in_flight = queued;

   function automatic vec_type saturate(input longint acc, inout logic sat);
      if (acc > COMP_MAX) begin
         sat = 1'b1;
         return vec_type'(COMP_MAX);
      end else if (acc < COMP_MIN) begin
         sat = 1'b1;
         return vec_type'(COMP_MIN);
      end
      return vec_type'(acc);
   endfunction

   function automatic transform_result_type predict_transform(input logic [CMD_W-1:0] cmd,
                                                              input vec_type vx,
                                                              input vec_type vy,
                                                              input vec_type vz);
      longint               m [3][3];
      longint               cf [3][3];
      longint               v [3];
      longint               acc [3];
      vec_type              comp [3];
      logic                 sat;
      transform_result_type res;
      sat  = 1'b0;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m[r][c] = coeff_type'(row_coeffs[r][COEFF_W*c +: COEFF_W]);
      // the spare command has its high bit set and so takes the normal path
      if (cmd[1]) begin
         cf[0][0] = m[1][1] * m[2][2] - m[2][1] * m[1][2];
         cf[0][1] = m[0][2] * m[2][1] - m[2][2] * m[0][1];
         cf[0][2] = m[0][1] * m[1][2] - m[1][1] * m[0][2];
         cf[1][0] = m[1][2] * m[2][0] - m[2][2] * m[1][0];
         cf[1][1] = m[0][0] * m[2][2] - m[2][0] * m[0][2];
         cf[1][2] = m[0][2] * m[1][0] - m[1][2] * m[0][0];
         cf[2][0] = m[1][0] * m[2][1] - m[2][0] * m[1][1];
         cf[2][1] = m[0][1] * m[2][0] - m[2][1] * m[0][0];
         cf[2][2] = m[0][0] * m[1][1] - m[1][0] * m[0][1];
         for (int r = 0; r < 3; r++) begin
            acc[r] = 0;
            for (int c = 0; c < 3; c++)
               acc[r] += (cf[r][c] * v[c]) >>> (2 * COEFF_FRAC_BITS);
         end
      end else begin
         for (int r = 0; r < 3; r++) begin
            acc[r] = 0;
            for (int c = 0; c < 3; c++)
               acc[r] += (m[r][c] * v[c]) >>> COEFF_FRAC_BITS;
            if (cmd == CMD_LOCATION)
               acc[r] += longint'(offsets[r]);
         end
      end
      for (int r = 0; r < 3; r++)
         comp[r] = saturate(acc[r], sat);
      res.x        = comp[0];
      res.y        = comp[1];
      res.z        = comp[2];
      res.overflow = sat;
      return res;
   endfunction

   task automatic compare_field(input string field, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      transform_result_type want;
      if (reset) begin
         row_coeffs[0] = ROW_ZERO_RESET;
         row_coeffs[1] = ROW_ONE_RESET;
         row_coeffs[2] = ROW_TWO_RESET;
         offsets[0]    = '0;
         offsets[1]    = '0;
         offsets[2]    = '0;
         pending_transforms.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_transforms.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result with no transaction outstanding", $time);
            end else begin
               want = pending_transforms.pop_front();
               compare_field("out_x", want.x, rsp_out_x);
               compare_field("out_y", want.y, rsp_out_y);
               compare_field("out_z", want.z, rsp_out_z);
               compare_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_ROW_ZERO: row_coeffs[0] = csr_wdata;
               REG_ROW_ONE:  row_coeffs[1] = csr_wdata;
               REG_ROW_TWO:  row_coeffs[2] = csr_wdata;
               REG_OFFSET_X: offsets[0] = csr_wdata[VEC_W-1:0];
               REG_OFFSET_Y: offsets[1] = csr_wdata[VEC_W-1:0];
               REG_OFFSET_Z: offsets[2] = csr_wdata[VEC_W-1:0];
               default: ;
            endcase
         end
         // a write-edge transaction sees the new rows and offsets; core cofactors lag
         if (start && !busy)
            pending_transforms.push_back(predict_transform(req_cmd, req_vec_x, req_vec_y,
                                                           req_vec_z));
      end
      queued <= pending_transforms.size();
   end

endmodule

// ===== bench/tb_affine_vector_transform_core.sv =====
`timescale 1ns / 1ps
// top of the affine vector transform bench: clock, reset, register programming and stimulus
// depends on avt_pkg, affine_vector_transform_core and avt_transform_checker

module tb_affine_vector_transform_core;
   import avt_pkg::*;

   localparam int PIPE_LATENCY     = 4;
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 212;
   localparam int QUIET_PHASE      = 3;
   localparam logic [CMD_W-1:0]     CMD_SPARE      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI  = 3'd7;
   localparam vec_type VEC_MAX = 32'sh7FFF_FFFF;
   localparam vec_type VEC_MIN = 32'sh8000_0000;
   localparam vec_type VEC_ONE = 32'sh0001_0000;
   localparam coeff_type COEFF_MAX = 16'sh7FFF;
   localparam coeff_type COEFF_MIN = 16'sh8000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd = CMD_LOCATION;
   logic signed [VEC_W-1:0] req_vec_x = '0;
   logic signed [VEC_W-1:0] req_vec_y = '0;
   logic signed [VEC_W-1:0] req_vec_z = '0;
   logic                    rsp_valid;
   logic signed [VEC_W-1:0] rsp_out_x;
   logic signed [VEC_W-1:0] rsp_out_y;
   logic signed [VEC_W-1:0] rsp_out_z;
   logic                    rsp_overflow;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   int unsigned             mismatch_count;
   int unsigned             transforms_in_flight;
   bit                      idle_enabled = 1'b1;

   affine_vector_transform_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_vec_x    (req_vec_x),
      .req_vec_y    (req_vec_y),
      .req_vec_z    (req_vec_z),
      .rsp_valid    (rsp_valid),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_overflow (rsp_overflow),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   avt_transform_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_vec_x            (req_vec_x),
      .req_vec_y            (req_vec_y),
      .req_vec_z            (req_vec_z),
      .rsp_valid            (rsp_valid),
      .rsp_out_x            (rsp_out_x),
      .rsp_out_y            (rsp_out_y),
      .rsp_out_z            (rsp_out_z),
      .rsp_overflow         (rsp_overflow),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .transforms_in_flight (transforms_in_flight)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb_affine_vector_transform_core: errors");
      $finish;
   end

   // leaves csr_we high; the caller lowers it after the last write of a batch
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic send_vector(input logic [CMD_W-1:0] cmd, input vec_type x, input vec_type y,
                              input vec_type z);
      if (idle_enabled)
         while ($urandom_range(99) < 14) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      do @(posedge clock); while (busy);
   endtask

   // holds the sender off until every outstanding transaction has come back
   task automatic wait_for_idle();
      @(posedge clock);
      while (transforms_in_flight != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   function automatic vec_type rand_component();
      case ($urandom_range(9))
         0:       return VEC_MAX;
         1:       return VEC_MIN;
         2, 3:    return vec_type'($urandom());
         4:       return vec_type'(int'($urandom_range(0, 65535)) - 32768);
         default: return vec_type'(int'($urandom_range(0, 16777215)) - 8388608);
      endcase
   endfunction

   function automatic coeff_type rand_coeff();
      case ($urandom_range(9))
         0:       return COEFF_MAX;
         1:       return COEFF_MIN;
         2:       return '0;
         3, 4:    return coeff_type'($urandom());
         default: return coeff_type'(int'($urandom_range(0, 16383)) - 8192);
      endcase
   endfunction

   function automatic logic [ROW_W-1:0] rand_row();
      return {rand_coeff(), rand_coeff(), rand_coeff()};
   endfunction

   // bits above the register width go out as well and must be ignored
   function automatic logic [CSR_DATA_W-1:0] rand_offset();
      logic [15:0] spare;
      spare = 16'($urandom());
      case ($urandom_range(7))
         0:       return {spare, VEC_MAX};
         1:       return {spare, VEC_MIN};
         2:       return {spare, 32'($urandom())};
         default: return {spare, rand_component()};
      endcase
   endfunction

   task automatic program_random();
      write_reg(REG_ROW_ZERO, rand_row());
      write_reg(REG_ROW_ONE, rand_row());
      write_reg(REG_ROW_TWO, rand_row());
      write_reg(REG_OFFSET_X, rand_offset());
      write_reg(REG_OFFSET_Y, rand_offset());
      write_reg(REG_OFFSET_Z, rand_offset());
      if ($urandom_range(1))
         write_reg($urandom_range(1) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                   CSR_DATA_W'({$urandom(), $urandom()}));
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrix out of reset, every command including the spare
      send_vector(CMD_LOCATION, VEC_ONE, 2 * VEC_ONE, -3 * VEC_ONE);
      send_vector(CMD_DIRECTION, VEC_MAX, VEC_MIN, -1);
      send_vector(CMD_NORMAL, VEC_MIN, VEC_MAX, '0);
      send_vector(CMD_SPARE, -1, -1, -1);
      send_vector(CMD_LOCATION, VEC_MAX, VEC_MAX, VEC_MAX);
      send_vector(CMD_LOCATION, VEC_MIN, VEC_MIN, VEC_MIN);
      start <= 1'b0;
      wait_for_idle();

      // extreme coefficients and offsets, saturation both ways
      write_reg(REG_ROW_ZERO, {COEFF_MAX, COEFF_MAX, COEFF_MAX});
      write_reg(REG_ROW_ONE, {COEFF_MIN, COEFF_MIN, COEFF_MIN});
      write_reg(REG_ROW_TWO, {COEFF_MIN, COEFF_MAX, 16'sd1});
      write_reg(REG_OFFSET_X, {16'hFFFF, VEC_MAX});
      write_reg(REG_OFFSET_Y, {16'h0000, VEC_MIN});
      write_reg(REG_OFFSET_Z, {16'hA5A5, 32'hFFFF_FFFF});
      write_reg(CSR_UNUSED_LO, '1);
      write_reg(CSR_UNUSED_HI, '0);
      csr_we <= 1'b0;
      wait_for_idle();
      send_vector(CMD_LOCATION, VEC_MAX, VEC_MAX, VEC_MAX);
      send_vector(CMD_LOCATION, VEC_MIN, VEC_MIN, VEC_MIN);
      send_vector(CMD_DIRECTION, VEC_MAX, VEC_MIN, VEC_MAX);
      send_vector(CMD_NORMAL, VEC_MAX, VEC_MAX, VEC_MAX);
      send_vector(CMD_SPARE, VEC_MIN, VEC_MIN, VEC_MIN);
      send_vector(CMD_NORMAL, VEC_MIN, VEC_MAX, -1);
      send_vector(CMD_DIRECTION, VEC_ONE, -VEC_ONE, '0);
      start <= 1'b0;
      wait_for_idle();

      // all-zero matrix: only the offsets survive a location
      write_reg(REG_ROW_ZERO, '0);
      write_reg(REG_ROW_ONE, '0);
      write_reg(REG_ROW_TWO, '0);
      write_reg(REG_OFFSET_X, {16'hFFFF, VEC_MIN});
      write_reg(REG_OFFSET_Y, '0);
      write_reg(REG_OFFSET_Z, {16'h0001, VEC_ONE});
      csr_we <= 1'b0;
      wait_for_idle();
      send_vector(CMD_LOCATION, VEC_MAX, VEC_MIN, VEC_ONE);
      send_vector(CMD_NORMAL, VEC_MAX, VEC_MIN, VEC_ONE);
      send_vector(CMD_DIRECTION, -1, VEC_MAX, VEC_MIN);
      start <= 1'b0;
      wait_for_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         program_random();
         wait_for_idle();
         // one phase runs back to back with no gaps at all
         idle_enabled = (phase != QUIET_PHASE);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_vector(CMD_W'($urandom_range(3)), rand_component(), rand_component(),
                        rand_component());
         start <= 1'b0;
         wait_for_idle();
      end

      if (mismatch_count == 0 && transforms_in_flight == 0)
         $display("tb_affine_vector_transform_core: clean");
      else
         $display("tb_affine_vector_transform_core: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/avt_pkg.sv
hw/rtl/affine_vector_transform_core.sv
bench/avt_transform_checker.sv
bench/tb_affine_vector_transform_core.sv
